### design/assert_macros.svh
// Assertion helpers used by the top-level design file.
// Every check is sampled on the rising edge of clk_i and is off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with reset disable.
`define SWTF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked implication: the consequent holds in the same cycle.
`define SWTF_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### design/swtf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtf_pkg
// Types, constants and helpers shared by the top-frequency sum unit.
// ----------------------------------------------------------------------------
package swtf_pkg;

  localparam int VAL_W = 32;
  localparam int CNT_W = 11;
  localparam int SUM_W = 38;
  localparam int CFG_W = 7;

  // Configuration register indexes.
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_TOP_COUNT     = 1'b1;

  // One table entry. A count of zero marks an empty cell.
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [VAL_W-1:0] val;
  } key_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic clear;
    logic del_en;
    logic ins_en;
    key_t key;
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_DEL,
    ST_INS,
    ST_PROD,
    ST_SUM,
    ST_SUM2,
    ST_OUT
  } state_e;

  // Ranks above every real entry; sits left of the first cell.
  localparam key_t KEY_MAX = '{cnt: '1, val: 32'h7fff_ffff};

  // Higher count first, then higher signed value.
  function automatic logic key_gt(key_t a, key_t b);
    logic [CNT_W+VAL_W-1:0] ka;
    logic [CNT_W+VAL_W-1:0] kb;
    ka = {a.cnt, ~a.val[VAL_W-1], a.val[VAL_W-2:0]};
    kb = {b.cnt, ~b.val[VAL_W-1], b.val[VAL_W-2:0]};
    return ka > kb;
  endfunction

endpackage

### design/sliding_window_top_frequency_sum_unit.sv
`timescale 1ns / 1ps
// A chain update runs match, delete shift, insert shift in turn. An item filling the
// window runs FIND, DEL, INS, PROD, SUM, SUM2 and OUT before its result is loaded.
// Samples are taken only in IDLE: after the add update and, once the window is full,
// after the product, adder tree, output (waits on m_axis_tready) and removal.
// Reset (asynchronous, active low) empties the window and the table at once.
// ----------------------------------------------------------------------------
// sliding_window_top_frequency_sum_unit
// Sliding-window sum of count times value over the most frequent samples.
// ----------------------------------------------------------------------------
module sliding_window_top_frequency_sum_unit #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // [31:0] sample_value
  input  logic [31:0]                 s_axis_tdata,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [37:0] x_sum, [39:38] zero
  output logic [39:0]                 m_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [swtf_pkg::CFG_W-1:0]  cfg_data_i
);
  import swtf_pkg::*;

  `include "assert_macros.svh"

  localparam int N  = WINDOW_MAX;
  localparam int AW = (N > 1) ? $clog2(N) : 1;
  localparam int FW = $clog2(N + 1);
  localparam int PW = FW + 1;

  state_e            state_q, state_d;
  logic [CFG_W-1:0]  wlen_q, tcount_q;
  logic [AW-1:0]     wp_q, wp_d;
  logic [FW-1:0]     fill_q, fill_d;
  logic [FW-1:0]     eff_len;
  logic [VAL_W-1:0]  val_q, val_d;
  logic              is_rm_q, is_rm_d;
  logic [CNT_W-1:0]  fc_q, fc_d, nc_q, nc_d;
  logic              del_q, del_d, ins_q, ins_d;
  logic              out_valid_q;
  logic [SUM_W-1:0]  x_sum_q;
  logic              out_load;
  logic              accept;

  op_t                      op;
  key_t  [N-1:0]            keys;
  logic  [N-1:0]            match;
  logic  [N-1:0][SUM_W-1:0] prods;
  logic  [SUM_W-1:0]        total;
  logic  [CNT_W-1:0]        found_cnt;
  logic                     found;
  logic  [VAL_W-1:0]        ram_rdata;
  logic                     ram_re;
  logic  [AW-1:0]           old_addr;
  logic  [PW-1:0]           wp_ext, fill_ext, old_ext;

  // Window length clamped to one through WINDOW_MAX.
  always_comb begin
    if (wlen_q == '0) begin
      eff_len = FW'(1);
    end else if (int'(wlen_q) > N) begin
      eff_len = FW'(N);
    end else begin
      eff_len = FW'(wlen_q);
    end
  end

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  // Slot of the oldest sample in the window.
  always_comb begin
    wp_ext   = PW'(wp_q);
    fill_ext = PW'(fill_q);
    if (wp_ext >= fill_ext) begin
      old_ext = wp_ext - fill_ext;
    end else begin
      old_ext = wp_ext + PW'(N) - fill_ext;
    end
    old_addr = AW'(old_ext);
  end

  assign ram_re = (state_q == ST_PROD);

  swtf_ram #(
    .WIDTH (VAL_W),
    .DEPTH (N)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wp_q),
    .wdata_i (s_axis_tdata),
    .re_i    (ram_re),
    .raddr_i (old_addr),
    .rdata_o (ram_rdata)
  );

  // Sorted chain of table cells.
  for (genvar i = 0; i < N; i++) begin : g_cell
    key_t left_k, right_k;
    if (i == 0) begin : g_first
      assign left_k = KEY_MAX;
    end else begin : g_mid
      assign left_k = keys[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_k = '0;
    end else begin : g_inner
      assign right_k = keys[i+1];
    end
    swtf_cell #(
      .INDEX (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op),
      .left_i      (left_k),
      .right_i     (right_k),
      .top_count_i (tcount_q),
      .key_o       (keys[i]),
      .match_o     (match[i]),
      .prod_o      (prods[i])
    );
  end

  swtf_sum_tree #(
    .N (N)
  ) u_tree (
    .clk_i  (clk_i),
    .prod_i (prods),
    .sum_o  (total)
  );

  // Count of the matching entry; at most one cell matches.
  always_comb begin
    found_cnt = '0;
    for (int i = 0; i < N; i++) begin
      if (match[i]) begin
        found_cnt = found_cnt | keys[i].cnt;
      end
    end
    found = |match;
  end

  // Command to the chain.
  always_comb begin
    op.clear   = cfg_we_i && (cfg_idx_i == REG_WINDOW_LENGTH);
    op.del_en  = (state_q == ST_DEL) && del_q;
    op.ins_en  = (state_q == ST_INS) && ins_q;
    op.key.val = val_q;
    op.key.cnt = (state_q == ST_DEL) ? fc_q : nc_q;
  end

  // Sequencer: next state and update of the working registers.
  always_comb begin
    state_d = state_q;
    wp_d    = wp_q;
    fill_d  = fill_q;
    val_d   = val_q;
    is_rm_d = is_rm_q;
    fc_d    = fc_q;
    nc_d    = nc_q;
    del_d   = del_q;
    ins_d   = ins_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          wp_d    = (int'(wp_q) == N - 1) ? '0 : wp_q + AW'(1);
          fill_d  = fill_q + FW'(1);
          val_d   = s_axis_tdata;
          is_rm_d = 1'b0;
          state_d = ST_FIND;
        end
      end
      ST_FIND: begin
        fc_d  = found_cnt;
        del_d = found;
        if (is_rm_q) begin
          nc_d  = found_cnt - CNT_W'(1);
          ins_d = found && (found_cnt != CNT_W'(1));
        end else begin
          nc_d  = found ? found_cnt + CNT_W'(1) : CNT_W'(1);
          ins_d = 1'b1;
        end
        state_d = ST_DEL;
      end
      ST_DEL: begin
        state_d = ST_INS;
      end
      ST_INS: begin
        if (is_rm_q || (fill_q < eff_len)) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_PROD;
        end
      end
      ST_PROD: begin
        state_d = ST_SUM;
      end
      ST_SUM: begin
        state_d = ST_SUM2;
      end
      ST_SUM2: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          val_d   = ram_rdata;
          is_rm_d = 1'b1;
          fill_d  = fill_q - FW'(1);
          state_d = ST_FIND;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // A new window length empties the window.
    if (cfg_we_i && (cfg_idx_i == REG_WINDOW_LENGTH)) begin
      wp_d   = '0;
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wp_q    <= '0;
      fill_q  <= '0;
      is_rm_q <= 1'b0;
      del_q   <= 1'b0;
      ins_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      fill_q  <= fill_d;
      is_rm_q <= is_rm_d;
      del_q   <= del_d;
      ins_q   <= ins_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    fc_q  <= fc_d;
    nc_q  <= nc_d;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q   <= CFG_W'(64);
      tcount_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW_LENGTH: wlen_q   <= cfg_data_i;
        REG_TOP_COUNT:     tcount_q <= cfg_data_i;
        default:           wlen_q   <= wlen_q;
      endcase
    end
  end

  // Output register; the next item may enter while a result waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      x_sum_q <= total;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, x_sum_q};

  `SWTF_ASSERT(a_match_unique, $onehot0(match), "two table cells hold the same value")
  `SWTF_ASSERT_IMP(a_rm_found, (state_q == ST_FIND) && is_rm_q, found,
                   "leaving sample missing from the table")
  `SWTF_ASSERT_IMP(a_idle_not_full, state_q == ST_IDLE, fill_q < eff_len,
                   "window full while idle")

endmodule

### design/swtf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtf_ram
// Simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module swtf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/swtf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtf_cell
// One slot of the sorted (count, value) chain with its weighted product.
// ----------------------------------------------------------------------------
module swtf_cell #(
  parameter int INDEX = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  swtf_pkg::op_t             op_i,
  input  swtf_pkg::key_t            left_i,
  input  swtf_pkg::key_t            right_i,
  input  logic [swtf_pkg::CFG_W-1:0] top_count_i,
  output swtf_pkg::key_t            key_o,
  output logic                      match_o,
  output logic [swtf_pkg::SUM_W-1:0] prod_o
);
  import swtf_pkg::*;

  key_t                     key_q;
  key_t                     key_d;
  logic signed [VAL_W+CNT_W:0] prod_full;
  logic [SUM_W-1:0]         prod_q;

  // Delete shifts the tail left; insert shifts the lower part right.
  always_comb begin
    key_d = key_q;
    if (op_i.clear) begin
      key_d = '0;
    end else if (op_i.del_en) begin
      if (!key_gt(key_q, op_i.key)) begin
        key_d = right_i;
      end
    end else if (op_i.ins_en) begin
      if (!key_gt(key_q, op_i.key)) begin
        key_d = key_gt(left_i, op_i.key) ? op_i.key : left_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  // Weighted value, kept only for ranks below the top count.
  assign prod_full = $signed(key_q.val) * $signed({1'b0, key_q.cnt});

  always_ff @(posedge clk_i) begin
    prod_q <= (INDEX < int'(top_count_i)) ? SUM_W'(prod_full) : '0;
  end

  assign key_o   = key_q;
  assign match_o = (key_q.cnt != '0) && (key_q.val == op_i.key.val);
  assign prod_o  = prod_q;

endmodule

### design/swtf_sum_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtf_sum_tree
// Two-level registered adder tree over the cell products.
// ----------------------------------------------------------------------------
module swtf_sum_tree #(
  parameter int N = 64
) (
  input  logic                             clk_i,
  input  logic [N-1:0][swtf_pkg::SUM_W-1:0] prod_i,
  output logic [swtf_pkg::SUM_W-1:0]        sum_o
);
  import swtf_pkg::*;

  localparam int NG = (N + 7) / 8;

  logic [NG-1:0][SUM_W-1:0] grp_q;
  logic [SUM_W-1:0]         sum_q;

  // First level: groups of eight products.
  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NG; g++) begin
      logic [SUM_W-1:0] s;
      s = '0;
      for (int k = 0; k < 8; k++) begin
        if (g * 8 + k < N) begin
          s = s + prod_i[g*8+k];
        end
      end
      grp_q[g] <= s;
    end
  end

  // Second level: total of the groups.
  always_ff @(posedge clk_i) begin
    logic [SUM_W-1:0] t;
    t = '0;
    for (int g = 0; g < NG; g++) begin
      t = t + grp_q[g];
    end
    sum_q <= t;
  end

  assign sum_o = sum_q;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sliding-window top-frequency sum unit. Samples
// go in over the input stream, and a local model keeps the window and works
// out each expected sum of count times value over the top-ranked values.
// Sums that come out are checked in order. Directed items cover the extremes,
// ties and the register corner cases. Random runs over many window settings
// follow, under three idle patterns and with a long output stall.
// ----------------------------------------------------------------------------
module tb;
  import swtf_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int WIN_MAX     = 64;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 30;
  localparam int HOLD_CYCLES = 400;

  typedef enum int {IDLE_TX_HEAVY, IDLE_RX_HEAVY, IDLE_NONE} idle_mode_e;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic [31:0]         s_axis_tdata  = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // [37:0] x_sum, [39:38] zero
  logic [39:0]         m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic                cfg_idx_i     = REG_WINDOW_LENGTH;
  logic [CFG_W-1:0]    cfg_data_i    = '0;

  // Local copy of the window and the registers.
  logic signed [31:0]  window_q[$];
  logic [CFG_W-1:0]    win_len_reg = 7'd64;
  logic [CFG_W-1:0]    top_cnt_reg = 7'd1;
  logic [39:0]         sum_expect_q[$];

  idle_mode_e          idle_mode = IDLE_NONE;
  int                  errors    = 0;
  int                  hold_left = 0;
  bit                  hold_req  = 1'b0;
  int                  quiet_cycles = 0;
  logic signed [31:0]  pool[8];

  sliding_window_top_frequency_sum_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
    errors++;
    $display("tb: mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
  endtask

  // Sum of count times value over the top_count best (count, value) pairs.
  function automatic logic [39:0] top_freq_sum();
    logic signed [31:0] vals[$];
    int                 cnts[$];
    longint             acc;
    int                 rank;
    bit                 found;
    acc = 0;
    foreach (window_q[k]) begin
      found = 1'b0;
      foreach (vals[d]) begin
        if (vals[d] == window_q[k]) begin
          cnts[d]++;
          found = 1'b1;
        end
      end
      if (!found) begin
        vals = {vals, window_q[k]};
        cnts = {cnts, 1};
      end
    end
    foreach (vals[i]) begin
      rank = 0;
      foreach (vals[j]) begin
        if (j != i && (cnts[j] > cnts[i] || (cnts[j] == cnts[i] && vals[j] > vals[i])))
          rank++;
      end
      if (rank < int'(top_cnt_reg))
        acc += longint'(cnts[i]) * longint'(vals[i]);
    end
    return {2'b00, acc[37:0]};
  endfunction

  // Model one accepted sample: a full window yields a sum and drops its oldest.
  task automatic predict_sample(input logic signed [31:0] v);
    int eff_len;
    eff_len = (win_len_reg == 0) ? 1 : (win_len_reg > WIN_MAX) ? WIN_MAX : int'(win_len_reg);
    window_q = {window_q, v};
    if (window_q.size() >= eff_len) begin
      sum_expect_q = {sum_expect_q, top_freq_sum()};
      void'(window_q.pop_front());
    end
  endtask

  // Offer one sample, at times after a random gap, and wait for it to be taken.
  task automatic send_sample(input logic [31:0] v);
    int idle_pct;
    idle_pct = (idle_mode == IDLE_TX_HEAVY) ? 29 : (idle_mode == IDLE_RX_HEAVY) ? 57 : 0;
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_sample(v);
  endtask

  // Stop offering and wait until the unit has nothing left in flight.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    wait (sum_expect_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic idx, input logic [CFG_W-1:0] data);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == REG_WINDOW_LENGTH) begin
      win_len_reg = data;
      window_q.delete();
    end else begin
      top_cnt_reg = data;
    end
  endtask

  // Mostly repeated values from a small pool so that counts grow and tie.
  function automatic logic [31:0] pick_sample();
    return ($urandom_range(99) < 80) ? pool[$urandom_range(7)] : $urandom();
  endfunction

  // Output side: check each sum and drive ready by the idle pattern unless a stall holds it low.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (sum_expect_q.size() == 0) report("unexpected sum", m_axis_tdata, '0);
      else if (m_axis_tdata !== sum_expect_q[0]) report("x_sum", m_axis_tdata, sum_expect_q[0]);
      if (sum_expect_q.size() != 0) void'(sum_expect_q.pop_front());
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (idle_mode)
        IDLE_TX_HEAVY: m_axis_tready <= ($urandom_range(99) >= 57);
        IDLE_RX_HEAVY: m_axis_tready <= ($urandom_range(99) >= 29);
        default:       m_axis_tready <= 1'b1;
      endcase
    end
  end

  // Watchdog on cycles without any accepted item or register write.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Reset values, sign extremes, ties and the register corner cases.
  task automatic test_directed();
    logic [31:0] edges[6];
    edges = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0, 32'h1, 32'h8000_0000};
    // Default setting: a 64-sample window summing the single top value.
    for (int i = 0; i < 66; i++) send_sample(pool[i % 3]);
    cfg_write(REG_WINDOW_LENGTH, 7'd4);
    cfg_write(REG_TOP_COUNT, 7'd2);
    foreach (edges[i]) send_sample(edges[i]);
    // Equal counts break the tie toward the higher value.
    for (int i = 0; i < 4; i++) send_sample(i[0] ? 32'h5 : 32'hffff_fffb);
    // Top count changes without emptying the window.
    cfg_write(REG_TOP_COUNT, 7'd0);
    for (int i = 0; i < 3; i++) send_sample(32'h7fff_ffff);
    cfg_write(REG_TOP_COUNT, 7'd127);
    for (int i = 0; i < 4; i++) send_sample(edges[i]);
  endtask

  // Window length at zero, at the maximum, and above it, with the largest sums.
  task automatic test_window_lengths();
    cfg_write(REG_WINDOW_LENGTH, 7'd0);
    for (int i = 0; i < 4; i++) send_sample(pick_sample());
    cfg_write(REG_WINDOW_LENGTH, 7'd127);
    cfg_write(REG_TOP_COUNT, 7'd64);
    for (int i = 0; i < 70; i++) send_sample(32'h8000_0000);
    cfg_write(REG_WINDOW_LENGTH, 7'd64);
    cfg_write(REG_TOP_COUNT, 7'd65);
    for (int i = 0; i < 70; i++) send_sample(i < 64 ? $urandom() : pick_sample());
  endtask

  // Random segments, each under a fresh window and top count.
  task automatic test_random(input idle_mode_e mode, input int n_items);
    int sent;
    int seg_len;
    idle_mode = mode;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0:       cfg_write(REG_WINDOW_LENGTH, 7'($urandom_range(16, 127)));
        1:       cfg_write(REG_WINDOW_LENGTH, 7'd0);
        default: cfg_write(REG_WINDOW_LENGTH, 7'($urandom_range(1, 8)));
      endcase
      cfg_write(REG_TOP_COUNT, ($urandom_range(9) == 0) ? 7'($urandom()) : 7'($urandom_range(4)));
      foreach (pool[i]) pool[i] = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(15) - 8;
      seg_len = $urandom_range(30, 60);
      for (int i = 0; i < seg_len; i++) begin
        send_sample(pick_sample());
        if (i == seg_len / 2 && $urandom_range(3) == 0)
          cfg_write(REG_TOP_COUNT, 7'($urandom_range(5)));
      end
      sent += seg_len;
    end
  endtask

  // Long output stall while samples keep being offered, then a full drain and more samples.
  task automatic test_backpressure();
    idle_mode = IDLE_NONE;
    cfg_write(REG_WINDOW_LENGTH, 7'd2);
    cfg_write(REG_TOP_COUNT, 7'd2);
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_sample(pick_sample());
    s_axis_tvalid <= 1'b0;
    wait (sum_expect_q.size() == 0);
    for (int i = 0; i < 10; i++) send_sample(pick_sample());
  endtask

  initial begin
    pool = '{32'h3, 32'hffff_fffd, 32'h7, 32'h3, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_window_lengths();
    test_random(IDLE_TX_HEAVY, 350);
    test_random(IDLE_RX_HEAVY, 350);
    test_random(IDLE_NONE, 350);
    test_backpressure();
    wait_idle();
    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
